FILE: sv/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg - scalar Kalman filter package
// Widths, reset values, register indexes, sequencer states and shared types.
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int WORD_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [WORD_W-1:0] Q_RESET   = 32'd107020;
    localparam logic [WORD_W-1:0] R_RESET   = 32'd65536;
    localparam logic [WORD_W-1:0] VAR_RESET = 32'd65536;
    localparam logic [GAIN_W-1:0] GAIN_MAX  = 16'hFFFF;
    localparam logic [GAIN_W:0]   GAIN_ONE  = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREDICT,
        S_SETUP,
        S_DIVIDE,
        S_MUL_EST,
        S_MUL_VAR,
        S_VAR,
        S_DONE
    } skf_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] process_noise;
        logic [WORD_W-1:0] measurement_noise;
    } skf_cfg_t;

endpackage

FILE: sv/skf_if.sv
// ----------------------------------------------------------------------------
// skf_if - scalar Kalman filter channel interfaces
// Valid/ready channels for samples, estimates and register writes.
// ----------------------------------------------------------------------------
interface skf_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [skf_pkg::WORD_W-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface skf_estimate_if;
    logic                                valid;
    logic                                ready;
    logic signed [skf_pkg::WORD_W-1:0]   estimate;

    modport source (output valid, output estimate, input ready);
    modport sink   (input valid, input estimate, output ready);
endinterface

interface skf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [skf_pkg::CFG_IDX_W-1:0]       index;
    logic [skf_pkg::WORD_W-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/skf_cfg_regs.sv
// ----------------------------------------------------------------------------
// skf_cfg_regs - noise register bank
// Holds process and measurement noise; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module skf_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    skf_cfg_if.sink           cfg,
    output skf_pkg::skf_cfg_t regs
);

    logic [skf_pkg::WORD_W-1:0] q_reg, q_next;
    logic [skf_pkg::WORD_W-1:0] r_reg, r_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        if (cfg.valid)
        begin
            if (cfg.index == skf_pkg::REG_PROCESS_NOISE)
                q_next = cfg.data;
            else if (cfg.index == skf_pkg::REG_MEASUREMENT_NOISE)
                r_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= skf_pkg::Q_RESET;
            r_reg <= skf_pkg::R_RESET;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign regs.process_noise     = q_reg;
    assign regs.measurement_noise = r_reg;

endmodule

FILE: sv/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter - one-dimensional Kalman filter, Q16.16
// Sequencer over a restoring divider step and one shared multiplier.
// ----------------------------------------------------------------------------
//  channel    dir  payload            transaction
//  cfg        in   index[7:0], data   register write, always ready
//  samples    in   sample (s32)       one altitude sample
//  estimates  out  estimate (s32)     one filtered estimate per sample
//
//  First sample after reset: accept, then output load.
//  Later samples: accept, predict, setup, 16 divider steps, two multiplies,
//  variance write, output load.
//  Zero measurement noise skips the divider steps.
//  samples.ready is high only while the sequencer is idle.
//  A waiting estimate is held in its register; the sequencer stalls at the
//  output load until that register is free.
// ----------------------------------------------------------------------------
module scalar_kalman_filter (
    input  logic            clk,
    input  logic            rst_n,
    skf_cfg_if.sink         cfg,
    skf_sample_if.sink      samples,
    skf_estimate_if.source  estimates
);

    localparam int W = skf_pkg::WORD_W;
    localparam int G = skf_pkg::GAIN_W;
    localparam int F = skf_pkg::FRAC_W;

    skf_pkg::skf_cfg_t   regs;
    skf_pkg::skf_state_t state_reg, state_next;

    logic                       first_reg, first_next;
    logic signed [W-1:0]        est_reg, est_next;
    logic [W-1:0]               var_reg, var_next;
    logic signed [W-1:0]        sample_reg;
    logic [W-1:0]               p_reg;
    logic signed [W:0]          diff_reg;
    logic [W:0]                 denom_reg;
    logic [W:0]                 rem_reg, rem_next;
    logic [G-1:0]               g_reg, g_next;
    logic [skf_pkg::CNT_W-1:0]  cnt_reg;
    logic signed [51:0]         prod_reg;
    logic                       out_valid_reg, out_valid_next;
    logic signed [W-1:0]        out_est_reg;

    logic                       in_ready;
    logic                       take_in;
    logic                       out_free;
    logic                       load_out;
    logic [W:0]                 p_sum;
    logic [W+1:0]               rem_sh;
    logic                       rem_ge;
    logic signed [33:0]         mul_a;
    logic signed [17:0]         mul_b;
    logic signed [51:0]         mul_p;
    logic signed [W:0]          step;
    logic signed [W+1:0]        est_sum;
    logic signed [W-1:0]        est_sat;

    skf_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign take_in  = samples.valid && in_ready;
    assign out_free = !out_valid_reg || estimates.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skf_pkg::S_IDLE:
                if (take_in)
                    state_next = first_reg ? skf_pkg::S_DONE : skf_pkg::S_PREDICT;
            skf_pkg::S_PREDICT: state_next = skf_pkg::S_SETUP;
            skf_pkg::S_SETUP:
                state_next = (regs.measurement_noise == '0) ? skf_pkg::S_MUL_EST
                                                             : skf_pkg::S_DIVIDE;
            skf_pkg::S_DIVIDE:
                if (cnt_reg == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1))
                    state_next = skf_pkg::S_MUL_EST;
            skf_pkg::S_MUL_EST: state_next = skf_pkg::S_MUL_VAR;
            skf_pkg::S_MUL_VAR: state_next = skf_pkg::S_VAR;
            skf_pkg::S_VAR:     state_next = skf_pkg::S_DONE;
            skf_pkg::S_DONE:
                if (out_free)
                    state_next = skf_pkg::S_IDLE;
            default:            state_next = skf_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            skf_pkg::S_IDLE:  in_ready = 1'b1;
            skf_pkg::S_DONE:  load_out = out_free;
            default: ;
        endcase
    end

    assign samples.ready = in_ready;

    // divider step
    assign p_sum  = {1'b0, var_reg} + {1'b0, regs.process_noise};
    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = rem_sh >= {1'b0, denom_reg};

    // shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            skf_pkg::S_MUL_EST:
            begin
                mul_a = 34'(diff_reg);
                mul_b = $signed({2'b00, g_reg});
            end
            skf_pkg::S_MUL_VAR:
            begin
                mul_a = $signed({2'b00, p_reg});
                mul_b = $signed({1'b0, skf_pkg::GAIN_ONE - {1'b0, g_reg}});
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // estimate update with saturation
    assign step    = prod_reg[48:F];
    assign est_sum = 34'(est_reg) + 34'(step);
    always_comb
    begin
        if (est_sum[W+1:W-1] == 3'b000 || est_sum[W+1:W-1] == 3'b111)
            est_sat = est_sum[W-1:0];
        else if (!est_sum[W+1])
            est_sat = {1'b0, {(W-1){1'b1}}};
        else
            est_sat = {1'b1, {(W-1){1'b0}}};
    end

    always_comb
    begin
        first_next = first_reg;
        est_next   = est_reg;
        var_next   = var_reg;
        rem_next   = rem_reg;
        g_next     = g_reg;
        unique case (state_reg)
            skf_pkg::S_IDLE:
                if (take_in && first_reg)
                begin
                    est_next   = samples.sample;
                    first_next = 1'b0;
                end
            skf_pkg::S_SETUP:
            begin
                rem_next = {1'b0, p_reg};
                if (regs.measurement_noise == '0)
                    g_next = (p_reg == '0) ? '0 : skf_pkg::GAIN_MAX;
                else
                    g_next = '0;
            end
            skf_pkg::S_DIVIDE:
            begin
                rem_next = rem_ge ? (W+1)'(rem_sh - {1'b0, denom_reg}) : rem_sh[W:0];
                g_next   = {g_reg[G-2:0], rem_ge};
            end
            skf_pkg::S_MUL_VAR: est_next = est_sat;
            skf_pkg::S_VAR:     var_next = prod_reg[47:F];
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (estimates.ready)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skf_pkg::S_IDLE;
            first_reg     <= 1'b1;
            est_reg       <= '0;
            var_reg       <= skf_pkg::VAR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            est_reg       <= est_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        g_reg    <= g_next;
        prod_reg <= mul_p;
        if (take_in)
            sample_reg <= samples.sample;
        if (state_reg == skf_pkg::S_PREDICT)
        begin
            p_reg    <= p_sum[W] ? {W{1'b1}} : p_sum[W-1:0];
            diff_reg <= 33'(sample_reg) - 33'(est_reg);
        end
        if (state_reg == skf_pkg::S_SETUP)
        begin
            denom_reg <= {1'b0, p_reg} + {1'b0, regs.measurement_noise};
            cnt_reg   <= '0;
        end
        else if (state_reg == skf_pkg::S_DIVIDE)
            cnt_reg <= cnt_reg + 1'b1;
        if (load_out)
            out_est_reg <= est_reg;
    end

    assign estimates.valid    = out_valid_reg;
    assign estimates.estimate = out_est_reg;

    a_first_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (take_in && first_reg) |=> (est_reg == $past(samples.sample)))
        else $error("first sample not taken as estimate");

    a_var_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == skf_pkg::S_VAR) |=> (var_reg <= $past(p_reg)))
        else $error("variance exceeds predicted variance");

    a_first_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !first_reg |=> !first_reg)
        else $error("first-sample flag set again");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !estimates.ready) |=> (out_valid_reg && $stable(out_est_reg)))
        else $error("pending estimate overwritten");

endmodule

FILE: test/tb_scalar_kalman_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter - self-checking bench for the scalar Kalman filter
// A directed table of samples and register writes, then randomised phases
// with new noise settings, each sample scored against a bit-exact filter
// model kept in step with every accepted transaction, or a typed expected value.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter;

    localparam int          RANDOM_ITEMS   = 1225;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          TAIL_CYCLES    = 60;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          DIR_ROWS       = 26;
    localparam logic [7:0]  IDX_UNUSED     = 8'h00;
    localparam logic [7:0]  REG_SPARE_LO   = 8'h02;
    localparam logic [7:0]  REG_SPARE_HI   = 8'hFF;
    localparam logic [31:0] S32_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN        = 32'h8000_0000;
    localparam logic [31:0] U32_MAX        = 32'hFFFF_FFFF;
    localparam longint      EST_HI         = longint'(2147483647);
    localparam longint      EST_LO         = -EST_HI - longint'(1);

    typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;
    typedef enum logic [1:0] { RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC } rx_mode_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  idx;
        logic [31:0] value;
        logic        typed;
        logic [31:0] want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    skf_cfg_if      cfg_if ();
    skf_sample_if   samples_if ();
    skf_estimate_if estimates_if ();

    scalar_kalman_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_if),
        .samples   (samples_if),
        .estimates (estimates_if)
    );

    // filter model state
    logic [31:0]        proc_noise;
    logic [31:0]        meas_noise;
    logic signed [31:0] filt_est;
    logic [31:0]        filt_var;
    logic               first_pending;

    logic [31:0] pending_estimates [$];
    int          mismatches;
    int          idle_cycles;
    int          hold_requests;
    int          hold_grants;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_SAMPLE, IDX_UNUSED,                     S32_MIN,       1'b1, S32_MIN},
        '{ROW_SAMPLE, IDX_UNUSED,                     S32_MIN,       1'b1, S32_MIN},
        '{ROW_SAMPLE, IDX_UNUSED,                     S32_MAX,       1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     32'h0,         1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     U32_MAX,       1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     32'h7FFF_0000, 1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     32'h8001_0000, 1'b0, 32'h0},
        '{ROW_WRITE,  skf_pkg::REG_MEASUREMENT_NOISE, 32'h0,         1'b0, 32'h0},
        '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE,     32'h0,         1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     32'h1234_5678, 1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     32'h1234_5678, 1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     32'hFFFF_FFFB, 1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     S32_MAX,       1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     S32_MIN,       1'b0, 32'h0},
        '{ROW_WRITE,  REG_SPARE_LO,                   U32_MAX,       1'b0, 32'h0},
        '{ROW_WRITE,  REG_SPARE_HI,                   U32_MAX,       1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     32'h4000_0000, 1'b0, 32'h0},
        '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE,     U32_MAX,       1'b0, 32'h0},
        '{ROW_WRITE,  skf_pkg::REG_MEASUREMENT_NOISE, U32_MAX,       1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     S32_MAX,       1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     S32_MIN,       1'b0, 32'h0},
        '{ROW_WRITE,  skf_pkg::REG_MEASUREMENT_NOISE, 32'h1,         1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     32'h0,         1'b0, 32'h0},
        '{ROW_SAMPLE, IDX_UNUSED,                     S32_MAX,       1'b0, 32'h0},
        '{ROW_WRITE,  skf_pkg::REG_PROCESS_NOISE,     skf_pkg::Q_RESET, 1'b0, 32'h0},
        '{ROW_WRITE,  skf_pkg::REG_MEASUREMENT_NOISE, skf_pkg::R_RESET, 1'b0, 32'h0}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // one filter update; returns the new estimate
    function automatic logic [31:0] filter_step(input logic signed [31:0] z);
        logic [32:0] p_wide;
        logic [31:0] p;
        logic [32:0] denom;
        logic [47:0] quot;
        logic [16:0] gain;
        logic [63:0] shrunk;
        longint      diff;
        longint      nxt;
        if (first_pending)
        begin
            filt_est      = z;
            first_pending = 1'b0;
        end
        else
        begin
            p_wide = {1'b0, filt_var} + {1'b0, proc_noise};
            p      = p_wide[32] ? U32_MAX : p_wide[31:0];
            denom  = {1'b0, p} + {1'b0, meas_noise};
            if (denom == '0)
                gain = '0;
            else
            begin
                quot = {p, 16'h0} / {15'h0, denom};
                gain = (quot > 48'(skf_pkg::GAIN_MAX)) ? {1'b0, skf_pkg::GAIN_MAX}
                                                       : quot[16:0];
            end
            diff = longint'(z) - longint'(filt_est);
            nxt  = longint'(filt_est) + ((diff * longint'(gain)) >>> skf_pkg::FRAC_W);
            if (nxt > EST_HI)
                nxt = EST_HI;
            if (nxt < EST_LO)
                nxt = EST_LO;
            filt_est = nxt[31:0];
            shrunk   = 64'(skf_pkg::GAIN_ONE - gain) * 64'(p);
            filt_var = shrunk[47:16];
        end
        return filt_est;
    endfunction

    function automatic logic [31:0] pick_sample();
        int unsigned roll;
        int unsigned span;
        longint      t;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            // altitude wandering around the current track
            span = 1 << $urandom_range(4, 22);
            t = longint'(filt_est) + longint'($urandom_range(0, 2 * span)) - longint'(span);
            if (t > EST_HI)
                t = EST_HI;
            if (t < EST_LO)
                t = EST_LO;
            return t[31:0];
        end
        else if (roll < 75)
            return $urandom;
        else if (roll < 85)
            return filt_est;
        else if (roll < 90)
            return S32_MAX;
        else if (roll < 95)
            return S32_MIN;
        return $urandom & 32'hFFFF_0000;
    endfunction

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return $urandom >> $urandom_range(8, 31);
            2:       return $urandom_range(0, 8) << skf_pkg::FRAC_W;
            3:       return ($urandom_range(0, 1) != 0) ? U32_MAX : 32'h0;
            default: return $urandom_range(0, 65536 * 4);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("estimate %s: expected %h, got %h", what, want, got);
    endtask

    task automatic wait_drained();
        while (pending_estimates.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == skf_pkg::REG_PROCESS_NOISE)
            proc_noise = value;
        else if (idx == skf_pkg::REG_MEASUREMENT_NOISE)
            meas_noise = value;
    endtask

    task automatic offer_sample(input logic [31:0] value, input logic typed,
                                input logic [31:0] typed_est);
        logic [31:0] want;
        samples_if.valid  <= 1'b1;
        samples_if.sample <= value;
        do
            @(posedge clk);
        while (!samples_if.ready);
        want = filter_step(value);
        pending_estimates.push_back(typed ? typed_est : want);
    endtask

    // estimate channel scoreboard
    always @(posedge clk)
    begin
        if (rst_n && estimates_if.valid && estimates_if.ready)
        begin
            if (pending_estimates.size() == 0)
                note_mismatch("with nothing pending", 32'h0, estimates_if.estimate);
            else if (pending_estimates[0] !== estimates_if.estimate)
                note_mismatch("mismatch", pending_estimates[0], estimates_if.estimate);
            if (pending_estimates.size() != 0)
                void'(pending_estimates.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((samples_if.valid && samples_if.ready) ||
            (estimates_if.valid && estimates_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_scalar_kalman_filter: errors");
            $finish;
        end
    end

    // estimate sink back-pressure
    initial
    begin
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        estimates_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_grants != hold_requests)
            begin
                hold_grants++;
                hold_left = $urandom_range(300, 500);
            end
            if (hold_left != 0)
            begin
                hold_left--;
                estimates_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   estimates_if.ready <= 1'b1;
                    RX_COIN:   estimates_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: estimates_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   estimates_if.ready <= ((mode_left % 8) != 0);
                endcase
            end
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned n;
        int unsigned burst_left;
        logic        bursty;
        logic [31:0] q_val;
        logic [31:0] r_val;
        mismatches    = 0;
        hold_requests = 0;
        hold_grants   = 0;
        proc_noise    = skf_pkg::Q_RESET;
        meas_noise    = skf_pkg::R_RESET;
        filt_est      = '0;
        filt_var      = skf_pkg::VAR_RESET;
        first_pending = 1'b1;
        rst_n             <= 1'b0;
        samples_if.valid  <= 1'b0;
        samples_if.sample <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(dir_rows[r].idx, dir_rows[r].value);
                if (r == DIR_ROWS - 1 || dir_rows[r + 1].kind != ROW_WRITE)
                    cfg_if.valid <= 1'b0;
            end
            else
            begin
                offer_sample(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].want);
                if (r == DIR_ROWS - 1 || dir_rows[r + 1].kind != ROW_SAMPLE)
                    samples_if.valid <= 1'b0;
            end
        end

        sent       = 0;
        phase      = 0;
        burst_left = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_drained();
            case (phase)
                0:       begin q_val = 32'h0;   r_val = 32'h0;   end
                1:       begin q_val = U32_MAX; r_val = U32_MAX; end
                2:       begin q_val = U32_MAX; r_val = 32'h0;   end
                3:       begin q_val = 32'h0;   r_val = U32_MAX; end
                4:
                begin
                    q_val = skf_pkg::Q_RESET;
                    r_val = skf_pkg::R_RESET;
                end
                default: begin q_val = pick_noise(); r_val = pick_noise(); end
            endcase
            if ($urandom_range(0, 1) != 0)
            begin
                write_reg(skf_pkg::REG_PROCESS_NOISE, q_val);
                write_reg(skf_pkg::REG_MEASUREMENT_NOISE, r_val);
            end
            else
            begin
                write_reg(skf_pkg::REG_MEASUREMENT_NOISE, r_val);
                write_reg(skf_pkg::REG_PROCESS_NOISE, q_val);
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(8'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
            cfg_if.valid <= 1'b0;

            n = $urandom_range(40, 120);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            bursty = ($urandom_range(0, 3) != 0);
            if (phase % 5 == 1)
            begin
                // long sink hold-off, source keeps pushing
                hold_requests++;
                bursty = 1'b0;
            end
            for (int i = 0; i < n; i++)
            begin
                offer_sample(pick_sample(), 1'b0, 32'h0);
                if (bursty)
                begin
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 32);
                        samples_if.valid <= 1'b0;
                        repeat ($urandom_range(1, 20)) @(posedge clk);
                    end
                    else
                        burst_left--;
                end
            end
            samples_if.valid <= 1'b0;
            sent  += n;
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_estimates.size() == 0)
            $display("tb_scalar_kalman_filter: clean");
        else
            $display("tb_scalar_kalman_filter: errors");
        $finish;
    end

endmodule

FILE: filelist.f
sv/skf_pkg.sv
sv/skf_if.sv
sv/skf_cfg_regs.sv
sv/scalar_kalman_filter.sv
test/tb_scalar_kalman_filter.sv
